FILE: hw/rtl/axis_angle_rotation_matrix_defines.svh
// Assertion helpers for the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
// assert that a implies b on the same edge
`define AARM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b on the next edge
`define AARM_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/aarm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;
    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] col0_row0;
        logic signed [15:0] col0_row1;
        logic signed [15:0] col0_row2;
        logic signed [15:0] col1_row0;
        logic signed [15:0] col1_row1;
        logic signed [15:0] col1_row2;
        logic signed [15:0] col2_row0;
        logic signed [15:0] col2_row1;
        logic signed [15:0] col2_row2;
    } t_out_item;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 64'sd536870912) >>> 30;
        if (r > 64'sd32767) return 16'sh7fff;
        if (r < -64'sd32768) return 16'sh8000;
        return r[15:0];
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix.
// Input channel: i_valid/o_ready with i_item (angle in 2^16-per-turn units, axis x/y/z Q1.14).
// Output channel: o_valid/i_ready with o_item, nine saturated Q1.14 entries.
// The pipeline is a chain of CORDIC cells, one per stage (at most 24),
// followed by three multiply/sum stages. One item is accepted per cycle
// while the output is not stalled.
// The whole chain advances together: while the output holds an item that
// the receiver does not take, every stage holds and o_ready drops. Bubbles
// inside the pipe are not squeezed out; only an empty or taken output lets it move.
// Reset clears all valid flags; data registers are not reset.
// The angle is folded to a half turn range before the chain and the signs
// of sine and cosine are restored after the last cell.
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_rotation_matrix_defines.svh"
module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 14
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire aarm_pkg::t_in_item i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output aarm_pkg::t_out_item  o_item
);
    localparam int NS = (CORDIC_STAGES < aarm_pkg::ATAN_ENTRIES) ?
                        CORDIC_STAGES : aarm_pkg::ATAN_ENTRIES;

    logic w_en;
    logic signed [33:0] c_x [NS+1];
    logic signed [33:0] c_y [NS+1];
    logic signed [33:0] c_z [NS+1];
    logic               c_v [NS+1];
    logic               c_f [NS+1];
    aarm_pkg::t_in_item c_i [NS+1];
    logic [31:0] w_phase;
    logic        w_flip;
    logic signed [33:0] w_c, w_s;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_phase = {i_item.angle, 16'h0000};
        w_flip  = w_phase[31] ^ w_phase[30];
        if (w_flip) w_phase[31] = ~w_phase[31];
    end

    assign c_x[0] = aarm_pkg::CORDIC_GAIN;
    assign c_y[0] = '0;
    assign c_z[0] = 34'(signed'(w_phase));
    assign c_v[0] = i_valid;
    assign c_f[0] = w_flip;
    assign c_i[0] = i_item;

    for (genvar g = 0; g < NS; g++) begin : g_cell
        aarm_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(c_v[g]), .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
            .i_flip(c_f[g]), .i_item(c_i[g]),
            .o_valid(c_v[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1]),
            .o_flip(c_f[g+1]), .o_item(c_i[g+1])
        );
    end

    assign w_c = c_f[NS] ? -c_x[NS] : c_x[NS];
    assign w_s = c_f[NS] ? -c_y[NS] : c_y[NS];

    aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(c_v[NS]), .i_c(w_c), .i_s(w_s), .i_item(c_i[NS]),
        .o_valid(o_valid), .o_item(o_item)
    );

    `AARM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item))
    `AARM_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !o_valid, o_ready)
endmodule
`default_nettype wire

FILE: hw/rtl/aarm_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module aarm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  wire signed [33:0] i_x,
    input  wire signed [33:0] i_y,
    input  wire signed [33:0] i_z,
    input  wire               i_flip,
    input  wire aarm_pkg::t_in_item i_item,
    output logic              o_valid,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y,
    output logic signed [33:0] o_z,
    output logic              o_flip,
    output aarm_pkg::t_in_item o_item
);
    logic signed [33:0] n_x, n_y, n_z;
    logic signed [33:0] w_t;

    always_comb begin
        w_t = aarm_pkg::atan_turn(5'(STAGE));
        if (!i_z[33]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - w_t;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_flip <= i_flip;
            o_item <= i_item;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/aarm_matrix.sv
`timescale 1ns / 1ps
`default_nettype none
module aarm_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  wire signed [33:0] i_c,
    input  wire signed [33:0] i_s,
    input  wire aarm_pkg::t_in_item i_item,
    output logic              o_valid,
    output aarm_pkg::t_out_item o_item
);
    // stage 1: pairwise axis products, s products, omc
    logic               r_v1, r_v2, r_v3;
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [63:0] r_xs, r_ys, r_zs, r_base1;
    logic signed [33:0] r_omc;
    // stage 2: outer terms
    logic signed [63:0] r_txx, r_tyy, r_tzz, r_txy, r_txz, r_tyz;
    logic signed [63:0] r_xs2, r_ys2, r_zs2, r_base2;
    logic signed [63:0] w_s;

    assign w_s = 64'(i_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
        end
        if (i_en) begin
            r_xx <= i_item.axis_x * i_item.axis_x;
            r_yy <= i_item.axis_y * i_item.axis_y;
            r_zz <= i_item.axis_z * i_item.axis_z;
            r_xy <= i_item.axis_x * i_item.axis_y;
            r_xz <= i_item.axis_x * i_item.axis_z;
            r_yz <= i_item.axis_y * i_item.axis_z;
            r_xs <= 64'(i_item.axis_x) * w_s;
            r_ys <= 64'(i_item.axis_y) * w_s;
            r_zs <= 64'(i_item.axis_z) * w_s;
            r_omc <= 34'sd1073741824 - i_c;
            r_base1 <= 64'(i_c) <<< FRAC_BITS;

            r_txx <= (64'(r_xx) * 64'(r_omc)) >>> FRAC_BITS;
            r_tyy <= (64'(r_yy) * 64'(r_omc)) >>> FRAC_BITS;
            r_tzz <= (64'(r_zz) * 64'(r_omc)) >>> FRAC_BITS;
            r_txy <= (64'(r_xy) * 64'(r_omc)) >>> FRAC_BITS;
            r_txz <= (64'(r_xz) * 64'(r_omc)) >>> FRAC_BITS;
            r_tyz <= (64'(r_yz) * 64'(r_omc)) >>> FRAC_BITS;
            r_xs2 <= r_xs; r_ys2 <= r_ys; r_zs2 <= r_zs; r_base2 <= r_base1;

            o_item.col0_row0 <= aarm_pkg::round_sat(r_base2 + r_txx);
            o_item.col0_row1 <= aarm_pkg::round_sat(r_txy + r_zs2);
            o_item.col0_row2 <= aarm_pkg::round_sat(r_txz - r_ys2);
            o_item.col1_row0 <= aarm_pkg::round_sat(r_txy - r_zs2);
            o_item.col1_row1 <= aarm_pkg::round_sat(r_base2 + r_tyy);
            o_item.col1_row2 <= aarm_pkg::round_sat(r_tyz + r_xs2);
            o_item.col2_row0 <= aarm_pkg::round_sat(r_txz + r_ys2);
            o_item.col2_row1 <= aarm_pkg::round_sat(r_tyz - r_xs2);
            o_item.col2_row2 <= aarm_pkg::round_sat(r_base2 + r_tzz);
        end
    end
    assign o_valid = r_v3;
endmodule
`default_nettype wire
